[src/idi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idi_pkg
// Shared constants and types of the inclusion dependency intersector.
// ----------------------------------------------------------------------------
package idi_pkg;

	localparam int MAX_CCS = 64;
	localparam int MASK_W  = 64;
	localparam int IDX_W   = 6;
	localparam int CC_W    = 7;

	localparam logic [CC_W-1:0] CC_RESET = CC_W'(64);

	localparam logic CMD_GROUP = 1'b0;
	localparam logic CMD_FINAL = 1'b1;

	typedef logic [MASK_W-1:0] mask_t;

	// Control that the sequencer broadcasts to every cell.
	typedef struct packed {
		logic upd;
		logic shift;
		logic clr;
	} cell_ctrl_t;

endpackage

[src/idi_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idi_if
// Stream and configuration channels of the inclusion dependency intersector.
// ----------------------------------------------------------------------------
interface idi_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	idi_pkg::mask_t     group_mask;

	modport source (output valid, output cmd, output group_mask, input ready);
	modport sink   (input valid, input cmd, input group_mask, output ready);
endinterface

interface idi_out_if;
	logic                      valid;
	logic                      ready;
	logic [idi_pkg::IDX_W-1:0] lhs_index;
	idi_pkg::mask_t            rhs_mask;
	logic                      lhs_seen;
	logic                      last;

	modport source (output valid, output lhs_index, output rhs_mask, output lhs_seen,
		output last, input ready);
	modport sink   (input valid, input lhs_index, input rhs_mask, input lhs_seen,
		input last, output ready);
endinterface

interface idi_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [idi_pkg::CC_W-1:0] cc_count;

	modport source (output valid, output cc_count, input ready);
	modport sink   (input valid, input cc_count, output ready);
endinterface

[src/idi_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idi_cell
// One candidate row: intersects with group beats and shifts toward cell zero.
// ----------------------------------------------------------------------------
module idi_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  idi_pkg::cell_ctrl_t ctrl,
	input  idi_pkg::mask_t      grp,
	input  logic                hit,
	input  idi_pkg::mask_t      self_mask,
	input  idi_pkg::mask_t      nxt_row,
	input  logic                nxt_seen,
	output idi_pkg::mask_t      row,
	output logic                seen
);

	idi_pkg::mask_t row_q;
	logic           seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (ctrl.clr) begin
			seen_q <= 1'b0;
		end else if (ctrl.shift) begin
			seen_q <= nxt_seen;
		end else if (ctrl.upd && hit) begin
			seen_q <= 1'b1;
		end
	end

	// The row itself carries no reset; the seen bit decides whether it is read.
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			row_q <= nxt_row;
		end else if (ctrl.upd && hit) begin
			row_q <= seen_q ? (row_q & grp) : (grp & ~self_mask);
		end
	end

	assign row  = row_q;
	assign seen = seen_q;

endmodule

[src/inclusion_dependency_intersector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inclusion_dependency_intersector
// Candidate inclusion dependency rows kept in a chain of cells.
// ----------------------------------------------------------------------------
// In a group beat, every cell whose bit is set in the masked group updates
// its row in parallel, and the next beat is taken in the next cycle. A
// finalize beat starts an emission of n rows, n being cc_count clamped to
// 1..64; the chain shifts down by one cell per emitted row, and it holds
// while the sink stalls the output register. No input is taken during the
// run. After the last row all seen bits clear in the same cycle.
module inclusion_dependency_intersector (
	input  logic       clk,
	input  logic       arst_n,
	idi_in_if.sink     items,
	idi_out_if.source  rows,
	idi_cfg_if.sink    cfg
);

	logic [idi_pkg::CC_W-1:0] cc_count_q;
	logic [idi_pkg::CC_W-1:0] n_act;
	idi_pkg::mask_t           act;
	idi_pkg::mask_t           grp;

	logic                     busy_q;
	logic [idi_pkg::CC_W-1:0] cnt_q;
	logic [idi_pkg::CC_W-1:0] n_q;
	idi_pkg::mask_t           act_q;

	logic                      out_valid_q;
	logic [idi_pkg::IDX_W-1:0] lhs_index_q;
	idi_pkg::mask_t            rhs_mask_q;
	logic                      lhs_seen_q;
	logic                      last_q;

	logic                in_acc;
	logic                load;
	logic                is_last;
	idi_pkg::cell_ctrl_t ctrl;

	idi_pkg::mask_t row_w  [idi_pkg::MAX_CCS];
	logic           seen_w [idi_pkg::MAX_CCS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_count_q <= idi_pkg::CC_RESET;
		end else if (cfg.valid) begin
			cc_count_q <= cfg.cc_count;
		end
	end

	always_comb begin
		if (cc_count_q == '0) begin
			n_act = idi_pkg::CC_W'(1);
		end else if (cc_count_q > idi_pkg::CC_W'(idi_pkg::MAX_CCS)) begin
			n_act = idi_pkg::CC_W'(idi_pkg::MAX_CCS);
		end else begin
			n_act = cc_count_q;
		end
		for (int i = 0; i < idi_pkg::MASK_W; i++) begin
			act[i] = (i < int'(n_act));
		end
	end

	assign grp         = items.group_mask & act;
	assign items.ready = !busy_q;
	assign in_acc      = items.valid && !busy_q;

	assign load    = busy_q && (!out_valid_q || rows.ready);
	assign is_last = ((cnt_q + idi_pkg::CC_W'(1)) == n_q);

	assign ctrl.upd   = in_acc && (items.cmd == idi_pkg::CMD_GROUP);
	assign ctrl.shift = load;
	assign ctrl.clr   = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc && (items.cmd == idi_pkg::CMD_FINAL)) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (load) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				cnt_q <= cnt_q + idi_pkg::CC_W'(1);
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rows.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The active count and mask are frozen for the whole run.
	always_ff @(posedge clk) begin
		if (in_acc && (items.cmd == idi_pkg::CMD_FINAL)) begin
			n_q   <= n_act;
			act_q <= act;
		end
		if (load) begin
			lhs_index_q <= cnt_q[idi_pkg::IDX_W-1:0];
			rhs_mask_q  <= seen_w[0] ? (row_w[0] & act_q) : '0;
			lhs_seen_q  <= seen_w[0];
			last_q      <= is_last;
		end
	end

	assign rows.valid     = out_valid_q;
	assign rows.lhs_index = lhs_index_q;
	assign rows.rhs_mask  = rhs_mask_q;
	assign rows.lhs_seen  = lhs_seen_q;
	assign rows.last      = last_q;

	for (genvar i = 0; i < idi_pkg::MAX_CCS; i++) begin : g_cell
		idi_pkg::mask_t nxt_row;
		logic           nxt_seen;

		if (i == idi_pkg::MAX_CCS - 1) begin : g_top
			assign nxt_row  = '0;
			assign nxt_seen = 1'b0;
		end else begin : g_mid
			assign nxt_row  = row_w[i+1];
			assign nxt_seen = seen_w[i+1];
		end

		idi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.grp       (grp),
			.hit       (grp[i]),
			.self_mask (idi_pkg::mask_t'(1) << i),
			.nxt_row   (nxt_row),
			.nxt_seen  (nxt_seen),
			.row       (row_w[i]),
			.seen      (seen_w[i])
		);
	end

endmodule
